[design/scp_pkg.sv]
// scp_pkg: shared constants, codes and result type of the serial command line parser
// no dependencies; used by scp_line_parser and serial_command_line_parser
package scp_pkg;

	localparam int LINE_BYTES = 64;
	localparam int LEN_W      = $clog2(LINE_BYTES);
	localparam int VAL_W      = 11;
	localparam int MAG_W      = 11;
	localparam int PROD_W     = 14;
	localparam int MAG_SAT    = 1001;
	localparam int VAL_MAX    = 1000;
	localparam int TDATA_W    = 48;
	localparam int TUSER_W    = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_W     = 8'h57;

	localparam logic [1:0] ST_VALID    = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_DRIVE  = 2'd1;
	localparam logic [1:0] KIND_WHEELS = 2'd2;
	localparam logic [1:0] KIND_MOTOR  = 2'd3;

	typedef struct packed {
		logic                    valid;
		logic [1:0]              status;
		logic [1:0]              kind;
		logic signed [VAL_W-1:0] value_a;
		logic signed [VAL_W-1:0] value_b;
		logic signed [VAL_W-1:0] value_c;
		logic signed [VAL_W-1:0] value_d;
		logic [2:0]              motor_number;
	} scp_result_t;

	// number of values a command carries
	function automatic logic [2:0] field_count(input logic [1:0] kind);
		logic [2:0] n;
		case (kind)
			KIND_DRIVE:  n = 3'd3;
			KIND_WHEELS: n = 3'd4;
			KIND_MOTOR:  n = 3'd2;
			default:     n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

[design/scp_line_parser.sv]
// scp_line_parser: per-line parse state and the single-step update for one byte
// depends on scp_pkg; result is combinational, registered by the top level
module scp_line_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output scp_pkg::scp_result_t result
);

	localparam logic [2:0] PH_LETTER = 3'd0;
	localparam logic [2:0] PH_COLON  = 3'd1;
	localparam logic [2:0] PH_LEAD   = 3'd2;
	localparam logic [2:0] PH_SIGNED = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	logic [scp_pkg::LEN_W-1:0] len_q, len_d;
	logic ovf_q, ovf_d;
	logic [2:0] ph_q, ph_d;
	logic fail_q, fail_d;
	logic ended_q, ended_d;
	logic ok_q, ok_d;
	logic [1:0] kind_q, kind_d;
	logic neg_q, neg_d;
	logic seen_q, seen_d;
	logic [scp_pkg::MAG_W-1:0] mag_q, mag_d;
	logic [1:0] fi_q, fi_d;
	logic signed [scp_pkg::VAL_W-1:0] cap_q [4];
	logic signed [scp_pkg::VAL_W-1:0] cap_d [4];

	logic [2:0] n_fields;
	logic [scp_pkg::PROD_W-1:0] prod;
	logic [scp_pkg::MAG_W-1:0] mag_clamp;
	logic signed [scp_pkg::VAL_W-1:0] cur;
	logic signed [scp_pkg::VAL_W-1:0] vals [4];
	logic motor_ok;
	logic end_ok;
	logic line_ok;
	logic is_digit;
	logic is_space;
	logic is_sign;
	logic clr;
	logic ovf_set;

	assign n_fields = scp_pkg::field_count(kind_q);
	assign prod = {{(scp_pkg::PROD_W-scp_pkg::MAG_W){1'b0}}, mag_q} * scp_pkg::PROD_W'(10)
		+ {{(scp_pkg::PROD_W-4){1'b0}}, rx_byte[3:0]};
	assign mag_clamp = (mag_q > scp_pkg::MAG_W'(scp_pkg::VAL_MAX)) ?
		scp_pkg::MAG_W'(scp_pkg::VAL_MAX) : mag_q;
	assign cur = neg_q ? -$signed(mag_clamp) : $signed(mag_clamp);

	assign is_digit = (rx_byte >= scp_pkg::CH_ZERO) && (rx_byte <= scp_pkg::CH_NINE);
	assign is_space = (rx_byte == scp_pkg::CH_SPACE) || (rx_byte == scp_pkg::CH_TAB) ||
		(rx_byte == scp_pkg::CH_VT) || (rx_byte == scp_pkg::CH_FF);
	assign is_sign = (rx_byte == scp_pkg::CH_PLUS) || (rx_byte == scp_pkg::CH_MINUS);

	assign motor_ok = (cap_q[0] >= 11'sd1) && (cap_q[0] <= 11'sd4);
	assign end_ok = !fail_q && (n_fields != 3'd0) && (ph_q == PH_DIGITS) && seen_q &&
		({1'b0, fi_q} == n_fields - 3'd1) && ((kind_q != scp_pkg::KIND_MOTOR) || motor_ok);
	assign line_ok = ended_q ? ok_q : end_ok;

	// values as they stand at the end of the content
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			vals[i] = (!ended_q && (fi_q == 2'(i))) ? cur : cap_q[i];
		end
	end

	always_comb begin
		len_d   = len_q;
		ovf_d   = ovf_q;
		ph_d    = ph_q;
		fail_d  = fail_q;
		ended_d = ended_q;
		ok_d    = ok_q;
		kind_d  = kind_q;
		neg_d   = neg_q;
		seen_d  = seen_q;
		mag_d   = mag_q;
		fi_d    = fi_q;
		cap_d   = cap_q;
		result  = '0;
		clr     = 1'b0;
		ovf_set = 1'b0;
		if (step) begin
			if (rx_byte == scp_pkg::CH_LF) begin
				clr = 1'b1;
				if (!ovf_q && (len_q != '0)) begin
					result.valid = 1'b1;
					if (line_ok) begin
						result.status = scp_pkg::ST_VALID;
						result.kind = kind_q;
						if (kind_q == scp_pkg::KIND_MOTOR) begin
							result.value_a = vals[1];
							result.motor_number = vals[0][2:0];
						end else begin
							result.value_a = vals[0];
							result.value_b = vals[1];
							result.value_c = vals[2];
							if (kind_q == scp_pkg::KIND_WHEELS) begin
								result.value_d = vals[3];
							end
						end
					end else begin
						result.status = scp_pkg::ST_INVALID;
					end
				end
			end else if ((rx_byte != scp_pkg::CH_CR) && !ovf_q) begin
				if (len_q < scp_pkg::LEN_W'(scp_pkg::LINE_BYTES - 1)) begin
					len_d = len_q + 1'b1;
					if (!ended_q && !fail_q) begin
						if (rx_byte == scp_pkg::CH_NUL) begin
							ended_d = 1'b1;
							ok_d = end_ok;
							cap_d[fi_q] = cur;
						end else begin
							case (ph_q)
								PH_LETTER: begin
									ph_d = PH_COLON;
									if (rx_byte == scp_pkg::CH_C) begin
										kind_d = scp_pkg::KIND_DRIVE;
									end else if (rx_byte == scp_pkg::CH_W) begin
										kind_d = scp_pkg::KIND_WHEELS;
									end else if (rx_byte == scp_pkg::CH_M) begin
										kind_d = scp_pkg::KIND_MOTOR;
									end else begin
										fail_d = 1'b1;
										ph_d = ph_q;
									end
								end
								PH_COLON: begin
									if (rx_byte == scp_pkg::CH_COLON) begin
										fi_d = 2'd0;
										neg_d = 1'b0;
										seen_d = 1'b0;
										mag_d = '0;
										ph_d = PH_LEAD;
									end else begin
										fail_d = 1'b1;
									end
								end
								PH_LEAD, PH_SIGNED: begin
									if ((ph_q == PH_LEAD) && is_space) begin
										ph_d = ph_q;
									end else if ((ph_q == PH_LEAD) && is_sign) begin
										neg_d = (rx_byte == scp_pkg::CH_MINUS);
										ph_d = PH_SIGNED;
									end else if (is_digit) begin
										mag_d = {{(scp_pkg::MAG_W-4){1'b0}}, rx_byte[3:0]};
										seen_d = 1'b1;
										ph_d = PH_DIGITS;
									end else begin
										fail_d = 1'b1;
									end
								end
								PH_DIGITS: begin
									if (is_digit) begin
										mag_d = (prod > scp_pkg::PROD_W'(scp_pkg::MAG_SAT)) ?
											scp_pkg::MAG_W'(scp_pkg::MAG_SAT) :
											prod[scp_pkg::MAG_W-1:0];
									end else if ((rx_byte == scp_pkg::CH_COMMA) &&
										(n_fields != 3'd0) &&
										(({1'b0, fi_q} + 3'd1) < n_fields)) begin
										cap_d[fi_q] = cur;
										fi_d = fi_q + 2'd1;
										neg_d = 1'b0;
										seen_d = 1'b0;
										mag_d = '0;
										ph_d = PH_LEAD;
									end else begin
										fail_d = 1'b1;
									end
								end
								default: begin
									fail_d = 1'b1;
								end
							endcase
						end
					end
				end else begin
					clr = 1'b1;
					ovf_set = 1'b1;
					result.valid = 1'b1;
					result.status = scp_pkg::ST_OVERFLOW;
				end
			end
		end
		if (clr) begin
			len_d   = '0;
			ovf_d   = 1'b0;
			ph_d    = PH_LETTER;
			fail_d  = 1'b0;
			ended_d = 1'b0;
			ok_d    = 1'b0;
			kind_d  = scp_pkg::KIND_NONE;
			neg_d   = 1'b0;
			seen_d  = 1'b0;
			mag_d   = '0;
			fi_d    = 2'd0;
			for (int i = 0; i < 4; i++) begin
				cap_d[i] = '0;
			end
		end
		if (ovf_set) begin
			ovf_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			ph_q    <= PH_LETTER;
			fail_q  <= 1'b0;
			ended_q <= 1'b0;
			ok_q    <= 1'b0;
			kind_q  <= scp_pkg::KIND_NONE;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			mag_q   <= '0;
			fi_q    <= 2'd0;
			for (int i = 0; i < 4; i++) begin
				cap_q[i] <= '0;
			end
		end else begin
			len_q   <= len_d;
			ovf_q   <= ovf_d;
			ph_q    <= ph_d;
			fail_q  <= fail_d;
			ended_q <= ended_d;
			ok_q    <= ok_d;
			kind_q  <= kind_d;
			neg_q   <= neg_d;
			seen_q  <= seen_d;
			mag_q   <= mag_d;
			fi_q    <= fi_d;
			for (int i = 0; i < 4; i++) begin
				cap_q[i] <= cap_d[i];
			end
		end
	end

endmodule

[design/serial_command_line_parser.sv]
// Serial command line parser: takes one received byte per request and reports one result
// per non-empty line ("C:f,t,s", "W:a,b,c,d", "M:i,v"), an invalid line, or a line overflow.
// Byte flow: s_tdata into an input register, one parse step, then the result register.
// The block takes one byte every cycle while the result register is not stalled. A byte waits
// in the input register until the parse step advances; its result, if any, is then registered
// and shown on m_tdata/m_tuser. The rate is set by the parse step (one multiply-by-ten-and-add
// on the running magnitude); a stalled result register holds the input register, and s_tready
// then follows m_tready combinationally.
module serial_command_line_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // rx_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// value_a, value_b, value_c, value_d, motor_number, zero pad
	output logic [scp_pkg::TDATA_W-1:0] m_tdata,
	output logic [scp_pkg::TUSER_W-1:0] m_tuser   // status, kind
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic advance;
	scp_pkg::scp_result_t res;
	scp_pkg::scp_result_t res_s2;
	logic valid_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	scp_line_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = {res_s2.kind, res_s2.status};
	assign m_tdata  = {1'b0, res_s2.motor_number, res_s2.value_d, res_s2.value_c,
		res_s2.value_b, res_s2.value_a};

	// error and overflow results carry nothing else
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != scp_pkg::ST_VALID) |->
		(m_tuser[3:2] == scp_pkg::KIND_NONE) && (m_tdata == '0))
		else $error("non-valid result carries data");

	// motor command carries an index in range
	a_motor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:2] == scp_pkg::KIND_MOTOR) |->
		(m_tdata[46:44] >= 3'd1) && (m_tdata[46:44] <= 3'd4))
		else $error("motor index out of range");

	// stall only comes from a held result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled without a held result");

	// a held result stays put until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |=> valid_s2 && $stable(res_s2))
		else $error("held result changed");

endmodule
